@@ sv/xrsg_pkg.sv @@
// Shared types and constants of the xorshift random string generator.
// Used by the register file, controller, datapath and top level.
package xrsg_pkg;

	// Longest string that one request may emit; longer lengths saturate.
	localparam int MAX_LEN = 64;

	localparam int LEN_W  = 7;
	localparam int WORD_W = 32;
	localparam int ADDR_W = 4;

	localparam logic [WORD_W-1:0] SEED_A_RST = 32'd123456789;
	localparam logic [WORD_W-1:0] SEED_B_RST = 32'd362436069;
	localparam logic [WORD_W-1:0] SEED_C_RST = 32'd521288629;
	localparam logic [WORD_W-1:0] SEED_D_RST = 32'd88675123;

	typedef enum logic [1:0] {
		KIND_WORD   = 2'd0,
		KIND_RAW    = 2'd1,
		KIND_ALNUM  = 2'd2,
		KIND_RELOAD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_SEED_FIRST  = 2'd0,
		REG_SEED_SECOND = 2'd1,
		REG_SEED_THIRD  = 2'd2,
		REG_SEED_FOURTH = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
		logic [WORD_W-1:0] third;
		logic [WORD_W-1:0] fourth;
	} seeds_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic gen_word;
		logic reload;
		logic start;
		logic fetch;
		logic next_byte;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  len_zero;
		logic  chunk_more;
		logic  rem_more;
	} status_t;

	// Maps a 5-bit index onto "abcdefghijklmnopqrstuvw012345678".
	function automatic logic [7:0] alpha_char(input logic [4:0] idx);
		logic [7:0] wide;
		begin
			wide = {3'b000, idx};
			if (idx < 5'd23) begin
				alpha_char = 8'h61 + wide;
			end else begin
				alpha_char = 8'h19 + wide;
			end
		end
	endfunction

endpackage

@@ sv/xorshift_random_string_generator.sv @@
// Top level of the xorshift random string generator.
// Instantiates xrsg_regs, xrsg_ctrl and xrsg_dp; depends on xrsg_pkg.
//
// Usage: a request item (kind, length) enters on in_valid/in_stall. Kind 0
// returns one 32-bit xorshift128 word, kind 3 reloads the generator from the
// seed registers and returns a zero word, kinds 1 and 2 return a raw or an
// alphanumeric string of length bytes (saturated to 64), one byte per item.
// The final item of every request carries last; an empty string returns none.
// Results leave on out_valid/out_stall from an output register.
// A word or reload result is valid in the cycle after the request is
// taken. A string takes one generator step per chunk of up to 4 bytes, then
// emits the bytes of the chunk one per item from the chunk word.
// Requests are handled one at a time; the next is taken the cycle after the
// last item of the previous one is delivered, which the single sequencer and
// its shared generator step set.
// When the receiver stalls, the output item holds and the generator waits.
// Reset restores the default seeds and the generator state to them.
// Seed registers sit at byte addresses 0, 4, 8 and 12 of the APB port.
module xorshift_random_string_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [xrsg_pkg::ADDR_W-1:0]   paddr,
	input  logic [xrsg_pkg::WORD_W-1:0]   pwdata,
	output logic [xrsg_pkg::WORD_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [xrsg_pkg::LEN_W-1:0]    length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [xrsg_pkg::WORD_W-1:0]   data,
	output logic                          last
);
	import xrsg_pkg::*;

	seeds_t  seeds;
	cmd_t    cmd;
	status_t status;

	xrsg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seeds   (seeds)
	);

	xrsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	xrsg_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.kind   (kind),
		.length (length),
		.seeds  (seeds),
		.cmd    (cmd),
		.status (status),
		.data   (data),
		.last   (last)
	);

endmodule

@@ sv/xrsg_regs.sv @@
// Seed register file behind the APB-style configuration port.
// Depends on xrsg_pkg for widths, register indexes and reset seeds.
module xrsg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [xrsg_pkg::ADDR_W-1:0]   paddr,
	input  logic [xrsg_pkg::WORD_W-1:0]   pwdata,
	output logic [xrsg_pkg::WORD_W-1:0]   prdata,
	output logic                          pready,
	output xrsg_pkg::seeds_t              seeds
);
	import xrsg_pkg::*;

	seeds_t   seeds_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign seeds  = seeds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeds_q.first  <= SEED_A_RST;
			seeds_q.second <= SEED_B_RST;
			seeds_q.third  <= SEED_C_RST;
			seeds_q.fourth <= SEED_D_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SEED_FIRST:  seeds_q.first  <= pwdata;
				REG_SEED_SECOND: seeds_q.second <= pwdata;
				REG_SEED_THIRD:  seeds_q.third  <= pwdata;
				REG_SEED_FOURTH: seeds_q.fourth <= pwdata;
				default:         seeds_q.first  <= seeds_q.first;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SEED_FIRST:  prdata = seeds_q.first;
			REG_SEED_SECOND: prdata = seeds_q.second;
			REG_SEED_THIRD:  prdata = seeds_q.third;
			REG_SEED_FOURTH: prdata = seeds_q.fourth;
			default:         prdata = '0;
		endcase
	end

endmodule

@@ sv/xrsg_ctrl.sv @@
// Controller state machine of the random string generator.
// Depends on xrsg_pkg for the state, command and status types.
module xrsg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  xrsg_pkg::status_t status,
	output xrsg_pkg::cmd_t    cmd
);
	import xrsg_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (status.kind)
						KIND_WORD: begin
							cmd.gen_word = 1'b1;
							state_d      = ST_EMIT;
						end
						KIND_RELOAD: begin
							cmd.reload = 1'b1;
							state_d    = ST_EMIT;
						end
						default: begin
							cmd.start = 1'b1;
							// An empty string gives no item and leaves the state alone.
							if (!status.len_zero) begin
								state_d = ST_FETCH;
							end
						end
					endcase
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (status.chunk_more) begin
						cmd.next_byte = 1'b1;
					end else if (status.rem_more) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ sv/xrsg_dp.sv @@
// Datapath: xorshift128 state, chunk word register, byte counters and output register.
// Depends on xrsg_pkg; driven by commands from xrsg_ctrl.
module xrsg_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    kind,
	input  logic [xrsg_pkg::LEN_W-1:0]    length,
	input  xrsg_pkg::seeds_t              seeds,
	input  xrsg_pkg::cmd_t                cmd,
	output xrsg_pkg::status_t             status,
	output logic [xrsg_pkg::WORD_W-1:0]   data,
	output logic                          last
);
	import xrsg_pkg::*;

	logic [WORD_W-1:0] gen_a_q, gen_b_q, gen_c_q, gen_d_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] data_q;
	logic              last_q;
	logic              alpha_q;
	logic              single_q;
	logic [1:0]        cnt_q;
	logic [LEN_W-1:0]  rem_q;

	logic [WORD_W-1:0] t1, t2, gen_next;
	logic [LEN_W-1:0]  len_sat;
	logic              rem_ge4, rem_ge2, rem_one;
	logic              fetch_single;
	logic [1:0]        fetch_cnt;
	logic [7:0]        fetch_byte, next_byte;

	// One xorshift step with shifts 11, 8 and 19.
	assign t1       = gen_a_q ^ (gen_a_q << 11);
	assign t2       = t1 ^ (t1 >> 8);
	assign gen_next = gen_d_q ^ (gen_d_q >> 19) ^ t2;

	always_comb begin
		if (MAX_LEN < (1 << LEN_W) && length > LEN_W'(MAX_LEN)) begin
			len_sat = LEN_W'(MAX_LEN);
		end else begin
			len_sat = length;
		end
	end

	assign rem_ge4 = rem_q >= LEN_W'(4);
	assign rem_ge2 = rem_q >= LEN_W'(2);
	assign rem_one = rem_q == LEN_W'(1);

	// Raw strings fetch the tail as a 2-byte and/or a 1-byte chunk; alphanumeric
	// strings spend a whole word on each trailing character.
	always_comb begin
		fetch_single = 1'b0;
		if (rem_ge4) begin
			fetch_cnt = 2'd3;
		end else if (alpha_q) begin
			fetch_cnt    = 2'd0;
			fetch_single = 1'b1;
		end else if (rem_ge2) begin
			fetch_cnt = 2'd1;
		end else begin
			fetch_cnt = 2'd0;
		end
	end

	always_comb begin
		if (!alpha_q) begin
			fetch_byte = gen_next[7:0];
		end else if (fetch_single) begin
			fetch_byte = alpha_char(gen_next[4:0]);
		end else begin
			fetch_byte = alpha_char(gen_next[7:3]);
		end
	end

	assign next_byte = alpha_q ? alpha_char(word_q[7:3]) : word_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q <= SEED_A_RST;
			gen_b_q <= SEED_B_RST;
			gen_c_q <= SEED_C_RST;
			gen_d_q <= SEED_D_RST;
		end else if (cmd.reload) begin
			gen_a_q <= seeds.first;
			gen_b_q <= seeds.second;
			gen_c_q <= seeds.third;
			gen_d_q <= seeds.fourth;
		end else if (cmd.gen_word || cmd.fetch) begin
			gen_a_q <= gen_b_q;
			gen_b_q <= gen_c_q;
			gen_c_q <= gen_d_q;
			gen_d_q <= gen_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			cnt_q    <= '0;
			alpha_q  <= 1'b0;
			single_q <= 1'b0;
		end else if (cmd.start) begin
			rem_q   <= len_sat;
			cnt_q   <= '0;
			alpha_q <= (kind_t'(kind) == KIND_ALNUM);
		end else if (cmd.fetch) begin
			rem_q    <= rem_q - LEN_W'(1);
			cnt_q    <= fetch_cnt;
			single_q <= fetch_single;
		end else if (cmd.next_byte) begin
			rem_q <= rem_q - LEN_W'(1);
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gen_word) begin
			data_q <= gen_next;
			last_q <= 1'b1;
		end else if (cmd.reload) begin
			data_q <= '0;
			last_q <= 1'b1;
		end else if (cmd.fetch) begin
			word_q <= gen_next >> 8;
			data_q <= {24'd0, fetch_byte};
			last_q <= rem_one;
		end else if (cmd.next_byte) begin
			word_q <= word_q >> 8;
			data_q <= {24'd0, next_byte};
			last_q <= rem_one;
		end
	end

	assign status.kind       = kind_t'(kind);
	assign status.len_zero   = (length == '0);
	assign status.chunk_more = (cnt_q != 2'd0) && !single_q;
	assign status.rem_more   = (rem_q != '0);

	assign data = data_q;
	assign last = last_q;

endmodule
